// ===== hdl/sfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SysEx frame assembler package
// Function codes, MIDI byte constants and the frame flag type.
// ----------------------------------------------------------------------------
package sfa_pkg;

    typedef enum logic [1:0] {
        FUNC_FEED    = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NONE    = 2'd3
    } sfa_func_t;

    localparam logic [7:0] BYTE_REALTIME = 8'hF8;
    localparam logic [7:0] BYTE_START    = 8'hF0;
    localparam logic [7:0] BYTE_END      = 8'hF7;

    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 7;
    localparam int INDEX_W = 8;
    localparam int LEN_W   = 9;

    typedef struct packed {
        logic in_frame;
        logic overflowed;
        logic ready;
    } sfa_flags_t;

endpackage

// ===== hdl/sfa_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SysEx frame store
// Single-port-write, registered-read buffer for the frame data bytes.
// ----------------------------------------------------------------------------
module sfa_store
    import sfa_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SysEx frame control
// Frame flags and byte count; decodes each word and issues the store write.
// ----------------------------------------------------------------------------
module sfa_ctrl
    import sfa_pkg::*;
#(
    parameter int MAX_FRAME = 256,
    parameter int AW        = 8,
    parameter int CW        = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  sfa_func_t         func,
    input  logic [BYTE_W-1:0] byte_in,
    output sfa_flags_t        flags_next,
    output logic [CW-1:0]     count_now,
    output logic [CW-1:0]     count_next,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [DATA_W-1:0] wr_data
);

    sfa_flags_t    flags_reg;
    sfa_flags_t    flags_upd;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_upd;
    logic          store_hit;

    always_comb
    begin
        flags_upd = flags_reg;
        count_upd = count_reg;
        store_hit = 1'b0;
        case (func)
            FUNC_FEED:
            begin
                if (!flags_reg.ready && byte_in < BYTE_REALTIME)
                begin
                    if (byte_in == BYTE_START)
                    begin
                        flags_upd.in_frame   = 1'b1;
                        flags_upd.overflowed = 1'b0;
                        count_upd            = '0;
                    end
                    else if (byte_in == BYTE_END)
                    begin
                        if (flags_reg.in_frame && !flags_reg.overflowed)
                        begin
                            flags_upd.ready = 1'b1;
                        end
                        flags_upd.in_frame = 1'b0;
                    end
                    else if (byte_in[BYTE_W-1])
                    begin
                        flags_upd.in_frame = 1'b0;
                    end
                    else if (flags_reg.in_frame)
                    begin
                        if (count_reg < CW'(MAX_FRAME))
                        begin
                            store_hit = 1'b1;
                            count_upd = count_reg + CW'(1);
                        end
                        else
                        begin
                            flags_upd.overflowed = 1'b1;
                        end
                    end
                end
            end
            FUNC_RELEASE:
            begin
                flags_upd.ready = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            flags_reg <= flags_upd;
            count_reg <= count_upd;
        end
    end

    assign flags_next = flags_upd;
    assign count_now  = count_reg;
    assign count_next = count_upd;
    assign wr_en      = step && store_hit;
    assign wr_addr    = count_reg[AW-1:0];
    assign wr_data    = byte_in[DATA_W-1:0];

endmodule

// ===== hdl/sysex_frame_assembler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SysEx frame assembler core
// Assembles one MIDI System Exclusive frame from a byte stream and serves
// release and read requests against the stored frame.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, func,        | into core
//           | byte_in, read_index              |
//   out     | out_valid, out_stall, frame_ready| out of core
//           | frame_length, read_byte          |
//
// One word per cycle while the result is not stalled; each word passes the
// input register, then the result register and the registered store read.
// Reset clears flags, count and valid bits; the store holds no reset.
// A stalled result holds; the input register keeps taking words while the
// result register is free or being taken this cycle.
// ----------------------------------------------------------------------------
module sysex_frame_assembler_core
    import sfa_pkg::*;
#(
    parameter int MAX_FRAME = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [BYTE_W-1:0]  byte_in,
    input  logic [INDEX_W-1:0] read_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_ready,
    output logic [LEN_W-1:0]   frame_length,
    output logic [DATA_W-1:0]  read_byte
);

    localparam int AW   = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int CW   = $clog2(MAX_FRAME + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int LXW  = (CW > LEN_W) ? CW : LEN_W;

    logic               s1_valid_reg;
    sfa_func_t          s1_func_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic [INDEX_W-1:0] s1_index_reg;

    logic               out_valid_reg;
    logic               ready_reg;
    logic [LEN_W-1:0]   length_reg;
    logic               hit_reg;

    logic               accept;
    logic               advance;
    sfa_flags_t         flags_next;
    logic [CW-1:0]      count_now;
    logic [CW-1:0]      count_next;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [DATA_W-1:0]  rd_data;
    logic [CMPW-1:0]    index_ext;
    logic [CMPW-1:0]    count_ext;
    logic [LXW-1:0]     length_ext;
    logic               hit_next;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= sfa_func_t'(func);
            s1_byte_reg  <= byte_in;
            s1_index_reg <= read_index;
        end
    end

    sfa_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .func       (s1_func_reg),
        .byte_in    (s1_byte_reg),
        .flags_next (flags_next),
        .count_now  (count_now),
        .count_next (count_next),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    assign index_ext  = CMPW'(s1_index_reg);
    assign count_ext  = CMPW'(count_now);
    assign hit_next   = (s1_func_reg == FUNC_READ) && (index_ext < count_ext);
    assign length_ext = LXW'(count_next);

    sfa_store #(
        .DEPTH (MAX_FRAME),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (advance),
        .rd_addr (index_ext[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ready_reg  <= flags_next.ready;
            length_reg <= length_ext[LEN_W-1:0];
            hit_reg    <= hit_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_ready  = ready_reg;
    assign frame_length = length_reg;
    assign read_byte    = hit_reg ? rd_data : '0;

endmodule
